/* rtl/lsfl_pkg.sv */
// Shared types and constants for the linked stack with free list.
package lsfl_pkg;

	// Default pool size
	localparam int POOL_DEPTH_DEF = 16;

	// Command codes
	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

endpackage

/* rtl/linked_stack_with_free_list.sv */
// Top level: LIFO stack as a linked list in a node pool, with a free list of popped nodes.
// For each item, in the cycle it is accepted the block reads the link word
// (and the data word) of the relevant list head from the pool RAMs, and in
// the S_EXEC state it then uses that link, writes the node back and loads
// the result register. S_EXEC is held for as long as the previous result
// still waits, untaken, in the result register. No clearing pass is needed
// after reset: the pool entries are always written by the push that links
// them before they are read.
module linked_stack_with_free_list #(
	parameter int POOL_DEPTH = lsfl_pkg::POOL_DEPTH_DEF,
	localparam int IDX_W = $clog2(POOL_DEPTH),
	localparam int CNT_W = $clog2(POOL_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [63:0]       push_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [63:0]       popped_value,
	output logic [IDX_W-1:0]  node_index,
	output logic [CNT_W-1:0]  stack_count,
	output logic [CNT_W-1:0]  free_count
);

	localparam logic [CNT_W-1:0] NIL = CNT_W'(POOL_DEPTH);

	lsfl_pkg::state_t state_q;
	logic [CNT_W-1:0] stack_head_q, free_head_q, fresh_used_q;
	logic [CNT_W-1:0] stack_size_q, free_size_q;
	logic             cmd_q;
	logic [63:0]      value_q;
	logic             out_valid_q;

	logic             accept, go;
	logic             rd_link_en;
	logic [IDX_W-1:0] rd_link_addr;
	logic [CNT_W-1:0] link_rd;
	logic [63:0]      data_rd;
	logic             link_we, data_we;
	logic [IDX_W-1:0] wr_node;
	logic [CNT_W-1:0] link_wdata;
	logic [IDX_W-1:0] node;
	lsfl_pkg::status_t st;
	logic [CNT_W-1:0] stack_head_d, free_head_d, fresh_used_d;
	logic [CNT_W-1:0] stack_size_d, free_size_d;
	logic [63:0]      popped_d;

	assign in_ready = (state_q == lsfl_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign go       = (state_q == lsfl_pkg::S_EXEC) && (!out_valid_q || out_ready);

	// Read the head's link: free head on push, stack head on pop
	assign rd_link_en   = accept;
	assign rd_link_addr = (cmd == lsfl_pkg::CMD_POP) ? stack_head_q[IDX_W-1:0]
	                                                 : free_head_q[IDX_W-1:0];

	lsfl_ram #(.WIDTH(CNT_W), .DEPTH(POOL_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (wr_node),
		.wdata (link_wdata),
		.re    (rd_link_en),
		.raddr (rd_link_addr),
		.rdata (link_rd)
	);

	lsfl_ram #(.WIDTH(64), .DEPTH(POOL_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (wr_node),
		.wdata (value_q),
		.re    (accept),
		.raddr (stack_head_q[IDX_W-1:0]),
		.rdata (data_rd)
	);

	// Work out the operation from the held beat and the link just read
	always_comb begin
		st           = lsfl_pkg::ST_OK;
		node         = '0;
		popped_d     = '0;
		link_we      = 1'b0;
		data_we      = 1'b0;
		link_wdata   = stack_head_q;
		stack_head_d = stack_head_q;
		free_head_d  = free_head_q;
		fresh_used_d = fresh_used_q;
		stack_size_d = stack_size_q;
		free_size_d  = free_size_q;
		if (cmd_q == lsfl_pkg::CMD_PUSH) begin
			if (free_head_q != NIL) begin
				node        = free_head_q[IDX_W-1:0];
				free_head_d = link_rd;
				if (free_size_q != '0) begin
					free_size_d = free_size_q - 1'b1;
				end
			end else if (fresh_used_q != NIL) begin
				node         = fresh_used_q[IDX_W-1:0];
				fresh_used_d = fresh_used_q + 1'b1;
			end else begin
				st = lsfl_pkg::ST_FULL;
			end
			if (st == lsfl_pkg::ST_OK) begin
				link_we      = go;
				data_we      = go;
				link_wdata   = stack_head_q;
				stack_head_d = CNT_W'(node);
				stack_size_d = stack_size_q + 1'b1;
			end
		end else begin
			if (stack_head_q == NIL) begin
				st = lsfl_pkg::ST_EMPTY;
			end else begin
				node         = stack_head_q[IDX_W-1:0];
				popped_d     = data_rd;
				stack_head_d = link_rd;
				if (stack_size_q != '0) begin
					stack_size_d = stack_size_q - 1'b1;
				end
				link_we     = go;
				link_wdata  = free_head_q;
				free_head_d = CNT_W'(node);
				free_size_d = free_size_q + 1'b1;
			end
		end
	end

	assign wr_node = node;

	// Sequencer and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lsfl_pkg::S_IDLE;
			stack_head_q <= NIL;
			free_head_q  <= NIL;
			fresh_used_q <= '0;
			stack_size_q <= '0;
			free_size_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				lsfl_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= lsfl_pkg::S_EXEC;
					end
				end
				lsfl_pkg::S_EXEC: begin
					if (go) begin
						state_q <= lsfl_pkg::S_IDLE;
					end
				end
				default: state_q <= lsfl_pkg::S_IDLE;
			endcase
			if (go) begin
				stack_head_q <= stack_head_d;
				free_head_q  <= free_head_d;
				fresh_used_q <= fresh_used_d;
				stack_size_q <= stack_size_d;
				free_size_q  <= free_size_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the input beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			value_q <= push_value;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (go) begin
			status       <= st;
			popped_value <= popped_d;
			node_index   <= node;
			stack_count  <= stack_size_d;
			free_count   <= free_size_d;
		end
	end

	assign out_valid = out_valid_q;

	// Every node handed out sits on exactly one list
	a_node_count: assert property (@(posedge clk) disable iff (!arst_n)
		(stack_size_q + free_size_q) == fresh_used_q)
		else $error("node count mismatch");

	// Empty stack list has a null head
	a_stack_nil: assert property (@(posedge clk) disable iff (!arst_n)
		(stack_head_q == NIL) == (stack_size_q == '0))
		else $error("stack head and size disagree");

	// Empty free list has a null head
	a_free_nil: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == NIL) == (free_size_q == '0))
		else $error("free head and size disagree");

	// A stalled result is never overwritten by the next operation
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !go)
		else $error("result overwritten while stalled");

endmodule

/* rtl/lsfl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lsfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
